### sv/ordered_key_value_table_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ordered key/value table
// Clocked, reset-qualified property wrappers used at the top level.
// ---------------------------------------------------------------------------
`ifndef ORDERED_KEY_VALUE_TABLE_UNIT_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define OKVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/okvt_pkg.sv
// ---------------------------------------------------------------------------
// okvt_pkg
// Shared types, request codes and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package okvt_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam int DEPTH_DEF       = 16;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ADD    = 2'd0;
  localparam kind_t KIND_SEARCH = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MISS,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_req;   // latch request, clear index and result flags
    logic idx_inc;
    logic rd_en;
    logic rd_next;    // read at index + 1
    logic wr_key;
    logic wr_val;
    logic wr_at_cnt;  // append slot instead of index
    logic wr_from_rd; // write back read data (shift down)
    logic hit_set;
    logic rej_set;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  key_match;
    logic  last;      // index + 1 >= count
    logic  cnt_zero;
    logic  full;
    logic  out_free;
  } dp_sts_t;

endpackage

### sv/okvt_if.sv
// ---------------------------------------------------------------------------
// okvt request / response channels
// Valid/ready channels carrying one request or one result per beat.
// ---------------------------------------------------------------------------
interface okvt_req_if;
  import okvt_pkg::*;

  logic                      valid;
  logic                      ready;
  kind_t                     kind;
  logic signed [KEY_W-1:0]   key;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface okvt_rsp_if;
  import okvt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [VALUE_W-1:0] old_value;
  logic                      rejected_full;
  logic [COUNT_W-1:0]        pair_count;

  modport source (output valid, found, old_value, rejected_full, pair_count,
                  input ready);
  modport sink   (input valid, found, old_value, rejected_full, pair_count,
                  output ready);
endinterface

### sv/okvt_ctrl.sv
// ---------------------------------------------------------------------------
// okvt_ctrl
// Request sequencer: scan, update, append and shift-down control.
// ---------------------------------------------------------------------------
module okvt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  okvt_pkg::kind_t  in_kind,
  output logic             in_ready,
  input  okvt_pkg::dp_sts_t sts,
  output okvt_pkg::dp_cmd_t cmd
);
  import okvt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          case (in_kind) inside
            KIND_ADD, KIND_SEARCH, KIND_REMOVE: begin
              state_nxt = sts.cnt_zero ? ST_MISS : ST_READ;
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.key_match) begin
          cmd.hit_set = 1'b1;
          state_nxt   = ST_FINISH;
          case (sts.kind)
            KIND_ADD: cmd.wr_val = 1'b1;
            KIND_REMOVE: begin
              cmd.cnt_dec = 1'b1;
              if (!sts.last) begin
                state_nxt = ST_SHIFT_RD;
              end
            end
            default: ;
          endcase
        end else if (!sts.last) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_READ;
        end else begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        if (sts.kind == KIND_ADD) begin
          if (sts.full) begin
            cmd.rej_set = 1'b1;
          end else begin
            cmd.wr_key    = 1'b1;
            cmd.wr_val    = 1'b1;
            cmd.wr_at_cnt = 1'b1;
            cmd.cnt_inc   = 1'b1;
          end
        end
        state_nxt = ST_FINISH;
      end
      ST_SHIFT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = 1'b1;
        state_nxt   = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        // count already decremented, so last here means the tail is moved
        cmd.wr_key     = 1'b1;
        cmd.wr_val     = 1'b1;
        cmd.wr_from_rd = 1'b1;
        cmd.idx_inc    = 1'b1;
        state_nxt      = sts.last ? ST_FINISH : ST_SHIFT_RD;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### sv/okvt_dp.sv
// ---------------------------------------------------------------------------
// okvt_dp
// Key/value memories, scan index, pair count and result register.
// ---------------------------------------------------------------------------
module okvt_dp #(
  parameter int DEPTH       = okvt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = okvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = okvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  okvt_pkg::kind_t                    in_kind,
  input  logic signed [okvt_pkg::KEY_W-1:0]   in_key,
  input  logic signed [okvt_pkg::VALUE_W-1:0] in_value,
  input  okvt_pkg::dp_cmd_t                  cmd,
  output okvt_pkg::dp_sts_t                  sts,
  okvt_rsp_if.source                         out_ch
);
  import okvt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem [DEPTH];

  kind_t                  req_kind_r;
  logic [KEY_WIDTH-1:0]   req_key_r;
  logic [VALUE_WIDTH-1:0] req_val_r;
  logic [AW-1:0]          idx_r;
  logic [CW-1:0]          cnt_r;
  logic                   found_r;
  logic                   rej_r;
  logic [VALUE_WIDTH-1:0] old_r;
  logic [KEY_WIDTH-1:0]   rd_key_r;
  logic [VALUE_WIDTH-1:0] rd_val_r;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic                   out_rej_r;
  logic [VALUE_W-1:0]     out_old_r;
  logic [COUNT_W-1:0]     out_cnt_r;

  logic [KEY_WIDTH+KEY_W-1:0]     key_ext;
  logic [VALUE_WIDTH+VALUE_W-1:0] val_ext;
  logic [VALUE_W+VALUE_WIDTH-1:0] old_ext;
  logic [COUNT_W+CW-1:0]          cnt_ext;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic [KEY_WIDTH-1:0]           wr_key_d;
  logic [VALUE_WIDTH-1:0]         wr_val_d;

  // field widths may differ from storage widths: zero-extend, then take low bits
  assign key_ext = {{KEY_WIDTH{1'b0}}, in_key};
  assign val_ext = {{VALUE_WIDTH{1'b0}}, in_value};
  assign old_ext = {{VALUE_W{1'b0}}, old_r};
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_r};

  assign rd_addr  = cmd.rd_next ? AW'(idx_r + AW'(1)) : idx_r;
  assign wr_addr  = cmd.wr_at_cnt ? cnt_r[AW-1:0] : idx_r;
  assign wr_key_d = cmd.wr_from_rd ? rd_key_r : req_key_r;
  assign wr_val_d = cmd.wr_from_rd ? rd_val_r : req_val_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_key) begin
      key_mem[wr_addr] <= wr_key_d;
    end
    if (cmd.wr_val) begin
      val_mem[wr_addr] <= wr_val_d;
    end
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind_r <= in_kind;
      req_key_r  <= key_ext[KEY_WIDTH-1:0];
      req_val_r  <= val_ext[VALUE_WIDTH-1:0];
    end
    if (cmd.load_req) begin
      old_r <= '0;
    end else if (cmd.hit_set) begin
      old_r <= rd_val_r;
    end
    if (cmd.out_load) begin
      out_found_r <= found_r;
      out_rej_r   <= rej_r;
      out_old_r   <= old_ext[VALUE_W-1:0];
      out_cnt_r   <= cnt_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        rej_r   <= 1'b0;
      end else begin
        if (cmd.idx_inc) begin
          idx_r <= AW'(idx_r + AW'(1));
        end
        if (cmd.hit_set) begin
          found_r <= 1'b1;
        end
        if (cmd.rej_set) begin
          rej_r <= 1'b1;
        end
      end
      if (cmd.cnt_inc) begin
        cnt_r <= CW'(cnt_r + CW'(1));
      end else if (cmd.cnt_dec) begin
        cnt_r <= CW'(cnt_r - CW'(1));
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.kind      = req_kind_r;
  assign sts.key_match = (rd_key_r == req_key_r);
  assign sts.last      = (CW'(CW'(idx_r) + CW'(1)) >= cnt_r);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.full      = (cnt_r == CW'(DEPTH));
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.old_value     = out_old_r;
  assign out_ch.rejected_full = out_rej_r;
  assign out_ch.pair_count    = out_cnt_r;

endmodule

### sv/ordered_key_value_table_unit.sv
// ---------------------------------------------------------------------------
// ordered_key_value_table_unit
// Insertion-ordered key/value table with add, search and remove requests.
// ---------------------------------------------------------------------------
// Holds up to DEPTH pairs in one key memory and one value memory, both with
// a single registered read port. A request is taken only when the sequencer
// is idle and yields exactly one result beat. Stored pairs are visited one
// slot at a time through that one read port (read, then compare), from slot
// 0 up to the first match or the pair count; a remove then moves every later
// pair down a slot (read, then write). The result sits in an output register,
// so the next request is accepted while a result waits. Memory contents need
// no clearing after reset; only the pair count, scan index, result flags and
// output valid are reset.
// ---------------------------------------------------------------------------
`include "ordered_key_value_table_unit_macros.svh"

module ordered_key_value_table_unit #(
  parameter int DEPTH       = okvt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = okvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = okvt_pkg::VALUE_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  okvt_req_if.sink   in_ch,
  okvt_rsp_if.source out_ch
);
  import okvt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ctl_in_ready;

  assign in_ch.ready = ctl_in_ready;

  okvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (ctl_in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  okvt_dp #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_kind  (in_ch.kind),
    .in_key   (in_ch.key),
    .in_value (in_ch.value),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

  `OKVT_ASSERT_NOW(a_no_append_when_full, cmd.cnt_inc, !sts.full, "append into full table")
  `OKVT_ASSERT_NOW(a_rej_not_found, out_ch.valid && out_ch.rejected_full, !out_ch.found, "rejected result also reports a hit")
  `OKVT_ASSERT_NEXT(a_one_req_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "second request taken while busy")
  `OKVT_ASSERT_NOW(a_no_load_over_result, cmd.out_load, sts.out_free, "result register overwritten")

endmodule

### tb/okvt_checker.sv
// ---------------------------------------------------------------------------
// okvt_checker
// Watches the request and result channels of the key/value table, keeps its
// own copy of the table and compares every result beat with the prediction.
// ---------------------------------------------------------------------------
module okvt_checker
  import okvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  okvt_req_if         req,
  okvt_rsp_if         rsp,
  output int unsigned mismatch_cnt,
  output int unsigned pending_cnt
);

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] old_value;
    logic               rejected_full;
    logic [COUNT_W-1:0] pair_count;
  } table_result_t;

  logic [KEY_W-1:0]   key_mem [DEPTH_DEF];
  logic [VALUE_W-1:0] val_mem [DEPTH_DEF];
  int                 n_pairs;
  table_result_t      result_q [$];

  initial begin
    mismatch_cnt = 0;
    pending_cnt  = 0;
    n_pairs      = 0;
  end

  // Linear scan, lowest matching slot wins; remove closes the gap.
  function automatic table_result_t apply_request(kind_t kind, logic [KEY_W-1:0] key,
                                                  logic [VALUE_W-1:0] value);
    table_result_t r;
    int            slot;
    r    = '0;
    slot = -1;
    if (kind == KIND_ADD || kind == KIND_SEARCH || kind == KIND_REMOVE) begin
      for (int i = 0; i < n_pairs; i++) begin
        if (slot < 0 && key_mem[i] == key) slot = i;
      end
      if (slot >= 0) begin
        r.found     = 1'b1;
        r.old_value = val_mem[slot];
        if (kind == KIND_ADD) begin
          val_mem[slot] = value;
        end else if (kind == KIND_REMOVE) begin
          for (int j = slot; j + 1 < n_pairs; j++) begin
            key_mem[j] = key_mem[j+1];
            val_mem[j] = val_mem[j+1];
          end
          n_pairs--;
        end
      end else if (kind == KIND_ADD) begin
        if (n_pairs < DEPTH_DEF) begin
          key_mem[n_pairs] = key;
          val_mem[n_pairs] = value;
          n_pairs++;
        end else begin
          r.rejected_full = 1'b1;
        end
      end
    end
    r.pair_count = COUNT_W'(n_pairs);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, name, want_v,
                 got_v);
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      n_pairs = 0;
      result_q.delete();
    end else begin
      // result first: it can only belong to an earlier request beat
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result beat with no request pending", $realtime);
        end else begin
          want = result_q.pop_front();
          check_field("found", 32'(want.found), 32'(rsp.found));
          check_field("old_value", want.old_value, rsp.old_value);
          check_field("rejected_full", 32'(want.rejected_full), 32'(rsp.rejected_full));
          check_field("pair_count", 32'(want.pair_count), 32'(rsp.pair_count));
        end
      end
      if (req.valid && req.ready)
        result_q.push_back(apply_request(req.kind, req.key, req.value));
    end
    pending_cnt = result_q.size();
  end

endmodule

### tb/tb_ordered_key_value_table_unit.sv
// ---------------------------------------------------------------------------
// tb_ordered_key_value_table_unit
// Drives add, search and remove requests into the key/value table: a short
// directed sweep of edge cases, then random traffic over a small key pool so
// the table fills, rejects, updates and shifts. Sender gaps and receiver
// stalls vary by phase; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_ordered_key_value_table_unit;
  import okvt_pkg::*;

  // request code with no operation behind it
  localparam kind_t KIND_UNUSED = 2'b11;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches;
  int unsigned in_flight;

  okvt_req_if req_ch ();
  okvt_rsp_if rsp_ch ();

  ordered_key_value_table_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  okvt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .mismatch_cnt (mismatches),
    .pending_cnt  (in_flight)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

  // Entered and left at a falling edge; valid stays high across back-to-back beats.
  task automatic send_req(kind_t kind_in, logic [31:0] key_in, logic [31:0] value_in);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      req_ch.key   <= $urandom;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind_in;
    req_ch.key   <= key_in;
    req_ch.value <= value_in;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic run_random(int n_items);
    logic [31:0] pool [24];
    logic        filling;
    int          pick;
    kind_t       kind;
    logic [31:0] key;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 24; i++) pool[i] = $urandom;
    filling = $urandom_range(1);
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) filling = ~filling;
      pick = $urandom_range(99);
      // fill mode pushes the table to full; drain mode empties it again
      if (filling) begin
        if (pick < 55)      kind = KIND_ADD;
        else if (pick < 78) kind = KIND_SEARCH;
        else if (pick < 95) kind = KIND_REMOVE;
        else                kind = KIND_UNUSED;
      end else begin
        if (pick < 20)      kind = KIND_ADD;
        else if (pick < 45) kind = KIND_SEARCH;
        else if (pick < 95) kind = KIND_REMOVE;
        else                kind = KIND_UNUSED;
      end
      key = ($urandom_range(99) < 85) ? pool[$urandom_range(23)] : $urandom;
      send_req(kind, key, $urandom);
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_ADD;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table: misses and the unused code
    send_req(KIND_SEARCH, 32'h0, 32'h0);
    send_req(KIND_REMOVE, 32'h0, 32'hffff_ffff);
    send_req(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_req(KIND_ADD, 32'h8000_0000, 32'h7fff_ffff);
    send_req(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000);
    send_req(KIND_ADD, 32'h0000_0000, 32'h0000_0000);
    send_req(KIND_ADD, 32'hffff_ffff, 32'hffff_ffff);
    send_req(KIND_ADD, 32'h8000_0000, 32'h1234_5678);
    send_req(KIND_SEARCH, 32'hffff_ffff, 32'h0);
    // remove at the head shifts every later pair down
    send_req(KIND_REMOVE, 32'h8000_0000, 32'h0);
    for (int i = 1; i <= 13; i++) send_req(KIND_ADD, 32'(i) * 32'h0101_0101, $urandom);
    send_req(KIND_ADD, 32'h5555_aaaa, 32'haaaa_5555);
    send_req(KIND_ADD, 32'h0000_0000, 32'h5555_aaaa);
    send_req(KIND_UNUSED, 32'h0000_0000, 32'h0);
    send_req(KIND_REMOVE, 32'(13) * 32'h0101_0101, 32'h0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      run_random(282);
      drain();
    end

    repeat (80) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(64'd40_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
